[rtl/core/smsc_pkg.sv]
package smsc_pkg;

	// Request kinds carried in the low bits of s_tuser.
	localparam logic [2:0] REQ_READ   = 3'd0;
	localparam logic [2:0] REQ_WRITE  = 3'd1;
	localparam logic [2:0] REQ_ID     = 3'd2;
	localparam logic [2:0] REQ_STATUS = 3'd3;
	localparam logic [2:0] REQ_ERASE  = 3'd4;

	// Save types.
	localparam logic [1:0] TYPE_NONE  = 2'd0;
	localparam logic [1:0] TYPE_SMALL = 2'd1;
	localparam logic [1:0] TYPE_EE16  = 2'd2;
	localparam logic [1:0] TYPE_FLASH = 2'd3;
	localparam logic [1:0] SAVE_TYPE_RESET = TYPE_FLASH;

	// Bus commands.
	localparam logic [7:0] CMD_RDID  = 8'h9f;
	localparam logic [7:0] CMD_RDSR  = 8'h05;
	localparam logic [7:0] CMD_READ  = 8'h03;
	localparam logic [7:0] CMD_WRITE = 8'h02;
	localparam logic [7:0] CMD_WREN  = 8'h06;
	localparam logic [7:0] CMD_SE    = 8'hd8;

	// Write chunk sizes per save type.
	localparam logic [8:0] CHUNK_SMALL = 9'd16;
	localparam logic [8:0] CHUNK_EE16  = 9'd32;
	localparam logic [8:0] CHUNK_FLASH = 9'd256;

	typedef enum logic [2:0] {
		ACT_SELECT   = 3'd0,
		ACT_SEND     = 3'd1,
		ACT_RECV     = 3'd2,
		ACT_DESELECT = 3'd3,
		ACT_WAIT     = 3'd4
	} action_t;

	// Fixed slot order of the actions one item can cause.
	localparam int NUM_SLOTS = 19;
	localparam int SLOT_W    = 5;
	localparam logic [SLOT_W-1:0] S_CLOSE_DESEL = 5'd0;
	localparam logic [SLOT_W-1:0] S_CPOLL_SEL   = 5'd1;
	localparam logic [SLOT_W-1:0] S_CPOLL_CMD   = 5'd2;
	localparam logic [SLOT_W-1:0] S_CPOLL_WAIT  = 5'd3;
	localparam logic [SLOT_W-1:0] S_CPOLL_DESEL = 5'd4;
	localparam logic [SLOT_W-1:0] S_WREN_SEL    = 5'd5;
	localparam logic [SLOT_W-1:0] S_WREN_CMD    = 5'd6;
	localparam logic [SLOT_W-1:0] S_WREN_DESEL  = 5'd7;
	localparam logic [SLOT_W-1:0] S_SEL         = 5'd8;
	localparam logic [SLOT_W-1:0] S_CMD         = 5'd9;
	localparam logic [SLOT_W-1:0] S_ARG0        = 5'd10;
	localparam logic [SLOT_W-1:0] S_ARG1        = 5'd11;
	localparam logic [SLOT_W-1:0] S_ARG2        = 5'd12;
	localparam logic [SLOT_W-1:0] S_BODY        = 5'd13;
	localparam logic [SLOT_W-1:0] S_END_DESEL   = 5'd14;
	localparam logic [SLOT_W-1:0] S_EPOLL_SEL   = 5'd15;
	localparam logic [SLOT_W-1:0] S_EPOLL_CMD   = 5'd16;
	localparam logic [SLOT_W-1:0] S_EPOLL_WAIT  = 5'd17;
	localparam logic [SLOT_W-1:0] S_EPOLL_DESEL = 5'd18;

	// One classified item: which slots fire and the bytes of the variable slots.
	// recv[i] turns slot S_ARG0+i into a receive instead of a send.
	typedef struct packed {
		logic [NUM_SLOTS-1:0] mask;
		logic [7:0]           cmd;
		logic [7:0]           arg0;
		logic [7:0]           arg1;
		logic [7:0]           arg2;
		logic [7:0]           body;
		logic [3:0]           recv;
	} job_t;

endpackage

[rtl/core/smsc_front.sv]
module smsc_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [1:0]        save_type,
	input  logic              accept,
	input  logic [2:0]        req_type,
	input  logic [23:0]       address,
	input  logic [7:0]        data_byte,
	input  logic              first,
	input  logic              last,
	output logic              push,
	output smsc_pkg::job_t    job
);
	import smsc_pkg::*;

	logic        frame_open_q;
	logic [8:0]  chunk_count_q;
	logic [23:0] next_address_q;

	logic        frame_open_d;
	logic [8:0]  chunk_count_d;
	logic [23:0] next_address_d;
	logic [23:0] addr_sel;
	logic [23:0] addr_inc;
	logic        close_en;
	logic        open_en;
	logic [7:0]  cmd_base;
	logic [8:0]  chunk_size;
	logic [8:0]  count_new;

	assign addr_sel = first ? address : next_address_q;
	assign addr_inc = addr_sel + 24'd1;

	always_comb begin
		case (save_type)
			TYPE_SMALL: chunk_size = CHUNK_SMALL;
			TYPE_EE16:  chunk_size = CHUNK_EE16;
			default:    chunk_size = CHUNK_FLASH;
		endcase
	end

	always_comb begin
		job            = '0;
		frame_open_d   = frame_open_q;
		chunk_count_d  = chunk_count_q;
		next_address_d = next_address_q;
		close_en       = 1'b0;
		open_en        = 1'b0;
		cmd_base       = CMD_READ;
		count_new      = 9'd0;
		case (req_type)
			REQ_READ: begin
				if (save_type != TYPE_NONE) begin
					open_en  = first || !frame_open_q || (chunk_count_q != 9'd0);
					close_en = open_en;
					cmd_base = CMD_READ;
					job.mask[S_BODY] = 1'b1;
					job.recv[3]      = 1'b1;
					next_address_d   = addr_inc;
					frame_open_d     = 1'b1;
					chunk_count_d    = 9'd0;
					if (last) begin
						job.mask[S_END_DESEL] = 1'b1;
						frame_open_d          = 1'b0;
					end
				end
			end
			REQ_WRITE: begin
				if (save_type != TYPE_NONE) begin
					open_en  = first || !frame_open_q || (chunk_count_q == 9'd0);
					close_en = open_en;
					cmd_base = CMD_WRITE;
					job.mask[S_WREN_SEL +: 3] = {3{open_en}};
					job.mask[S_BODY]          = 1'b1;
					job.body                  = data_byte;
					count_new      = (open_en ? 9'd0 : chunk_count_q) + 9'd1;
					next_address_d = addr_inc;
					frame_open_d   = 1'b1;
					chunk_count_d  = count_new;
					if (count_new >= chunk_size || last) begin
						job.mask[S_END_DESEL]    = 1'b1;
						job.mask[S_EPOLL_SEL +: 4] = 4'hf;
						frame_open_d  = 1'b0;
						chunk_count_d = 9'd0;
					end
				end
			end
			REQ_ID: begin
				close_en          = 1'b1;
				job.mask[S_SEL]   = 1'b1;
				job.mask[S_CMD]   = 1'b1;
				job.cmd           = CMD_RDID;
				job.mask[S_ARG0 +: 3] = 3'b111;
				job.recv[2:0]     = 3'b111;
				job.mask[S_END_DESEL] = 1'b1;
				frame_open_d      = 1'b0;
				chunk_count_d     = 9'd0;
			end
			REQ_STATUS: begin
				close_en          = 1'b1;
				job.mask[S_SEL]   = 1'b1;
				job.mask[S_CMD]   = 1'b1;
				job.cmd           = CMD_RDSR;
				job.mask[S_ARG0]  = 1'b1;
				job.recv[0]       = 1'b1;
				job.mask[S_END_DESEL] = 1'b1;
				frame_open_d      = 1'b0;
				chunk_count_d     = 9'd0;
			end
			REQ_ERASE: begin
				if (save_type == TYPE_FLASH) begin
					close_en = 1'b1;
					job.mask[S_WREN_SEL +: 3] = 3'b111;
					job.mask[S_SEL]           = 1'b1;
					job.mask[S_CMD]           = 1'b1;
					job.cmd                   = CMD_SE;
					job.mask[S_ARG0 +: 3]     = 3'b111;
					job.arg0                  = address[7:0];
					job.mask[S_END_DESEL]     = 1'b1;
					job.mask[S_EPOLL_SEL +: 4] = 4'hf;
					frame_open_d  = 1'b0;
					chunk_count_d = 9'd0;
				end
			end
			default: begin
			end
		endcase

		// Opening a read or write frame: select, command and address bytes.
		if (open_en) begin
			job.mask[S_SEL]  = 1'b1;
			job.mask[S_CMD]  = 1'b1;
			job.mask[S_ARG0] = (save_type == TYPE_FLASH);
			job.mask[S_ARG1] = (save_type != TYPE_SMALL);
			job.mask[S_ARG2] = 1'b1;
			job.arg0         = addr_sel[23:16];
			job.arg1         = addr_sel[15:8];
			job.arg2         = addr_sel[7:0];
			job.cmd          = (save_type == TYPE_SMALL) ?
				(cmd_base | {4'd0, addr_sel[8], 3'd0}) : cmd_base;
		end

		// A frame left open is closed first; a write frame also waits for ready.
		if (close_en && frame_open_q) begin
			job.mask[S_CLOSE_DESEL]    = 1'b1;
			job.mask[S_CPOLL_SEL +: 4] = {4{chunk_count_q != 9'd0}};
		end
	end

	assign push = accept && (job.mask != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_open_q   <= 1'b0;
			chunk_count_q  <= 9'd0;
			next_address_q <= 24'd0;
		end else if (accept) begin
			frame_open_q   <= frame_open_d;
			chunk_count_q  <= chunk_count_d;
			next_address_q <= next_address_d;
		end
	end

	a_count_needs_frame: assert property (@(posedge clk) disable iff (!arst_n)
		!frame_open_q |-> chunk_count_q == 9'd0)
		else $error("chunk count set with no frame open");

	a_count_below_max: assert property (@(posedge clk) disable iff (!arst_n)
		chunk_count_q < CHUNK_FLASH)
		else $error("write chunk not closed at its size");

	a_push_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> accept && job.mask[NUM_SLOTS-1:S_BODY] != '0)
		else $error("queued job has no closing action");

endmodule

[rtl/core/smsc_queue.sv]
module smsc_queue #(
	parameter int DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  smsc_pkg::job_t push_job,
	input  logic           pop,
	output smsc_pkg::job_t head_job,
	output logic           empty,
	output logic           full
);
	import smsc_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign empty    = (count_q == '0);
	assign full     = (count_q == CNT_W'(DEPTH));
	assign head_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[rtl/core/smsc_back.sv]
module smsc_back (
	input  logic           clk,
	input  logic           arst_n,
	input  smsc_pkg::job_t head_job,
	input  logic           q_empty,
	output logic           pop,
	output logic           m_tvalid,
	input  logic           m_tready,
	output logic [7:0]     m_tdata,
	output logic [2:0]     m_tuser,
	output logic           m_tlast
);
	import smsc_pkg::*;

	job_t                 job_q;
	logic [NUM_SLOTS-1:0] rem_q;
	logic                 out_valid_q;
	logic [7:0]           out_byte_q;
	action_t              out_act_q;
	logic                 out_last_q;

	logic                 advance;
	logic                 emit;
	logic [NUM_SLOTS-1:0] low_bit;
	logic [NUM_SLOTS-1:0] rem_after;
	logic [SLOT_W-1:0]    slot;
	action_t              act;
	logic [7:0]           act_byte;

	assign advance   = !out_valid_q || m_tready;
	assign emit      = advance && (rem_q != '0);
	assign low_bit   = rem_q & (~rem_q + 1'b1);
	assign rem_after = emit ? (rem_q & ~low_bit) : rem_q;
	assign pop       = (rem_after == '0) && !q_empty;

	always_comb begin
		slot = '0;
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (rem_q[i]) begin
				slot = SLOT_W'(i);
			end
		end
	end

	always_comb begin
		act      = ACT_DESELECT;
		act_byte = 8'd0;
		case (slot)
			S_CPOLL_SEL, S_WREN_SEL, S_SEL, S_EPOLL_SEL: act = ACT_SELECT;
			S_CPOLL_CMD, S_EPOLL_CMD: begin
				act      = ACT_SEND;
				act_byte = CMD_RDSR;
			end
			S_WREN_CMD: begin
				act      = ACT_SEND;
				act_byte = CMD_WREN;
			end
			S_CPOLL_WAIT, S_EPOLL_WAIT: act = ACT_WAIT;
			S_CMD: begin
				act      = ACT_SEND;
				act_byte = job_q.cmd;
			end
			S_ARG0: begin
				act      = job_q.recv[0] ? ACT_RECV : ACT_SEND;
				act_byte = job_q.recv[0] ? 8'd0 : job_q.arg0;
			end
			S_ARG1: begin
				act      = job_q.recv[1] ? ACT_RECV : ACT_SEND;
				act_byte = job_q.recv[1] ? 8'd0 : job_q.arg1;
			end
			S_ARG2: begin
				act      = job_q.recv[2] ? ACT_RECV : ACT_SEND;
				act_byte = job_q.recv[2] ? 8'd0 : job_q.arg2;
			end
			S_BODY: begin
				act      = job_q.recv[3] ? ACT_RECV : ACT_SEND;
				act_byte = job_q.recv[3] ? 8'd0 : job_q.body;
			end
			default: begin
				act      = ACT_DESELECT;
				act_byte = 8'd0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= head_job;
		end
		if (emit) begin
			out_byte_q <= act_byte;
			out_act_q  <= act;
			out_last_q <= (rem_after == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			rem_q <= pop ? head_job.mask : rem_after;
			if (advance) begin
				out_valid_q <= emit;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;
	assign m_tuser  = out_act_q;
	assign m_tlast  = out_last_q;

	a_pop_when_done: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_empty && rem_after == '0)
		else $error("job loaded over unfinished job");

	a_byte_only_on_send: assert property (@(posedge clk) disable iff (!arst_n)
		emit && act != ACT_SEND |-> act_byte == 8'd0)
		else $error("nonzero byte on a non-send beat");

	a_last_ends_job: assert property (@(posedge clk) disable iff (!arst_n)
		emit && rem_after == '0 |=> m_tvalid && m_tlast)
		else $error("final beat of a job not marked last");

endmodule

[rtl/core/save_memory_spi_command_sequencer_unit.sv]
// The first bus action of an item passes the job queue, then the back end's job register
// and output register. Throughput: one action per cycle while m_tready is high; an item
// causes 1 to 19 actions as the back end steps its slot mask; ignored requests cause none.
// A QUEUE_DEPTH-entry job queue lets the front accept one item per cycle until it fills.
// Reset clears frame state, the next address and the queue; save_type returns to 3.
module save_memory_spi_command_sequencer_unit #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	// APB configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// Requests
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // address[23:0], data_byte[31:24]
	input  logic [3:0]  s_tuser,   // req_type[2:0], first[3]
	input  logic        s_tlast,   // last
	// Bus actions
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // bus_byte[7:0]
	output logic [2:0]  m_tuser,   // action[2:0]
	output logic        m_tlast    // end_of_run
);
	import smsc_pkg::*;

	localparam logic [1:0] ADDR_SAVE_TYPE = 2'd0;

	logic [1:0] save_type_q;
	logic       accept;
	logic       push;
	logic       pop;
	logic       q_empty;
	logic       q_full;
	job_t       push_job;
	job_t       head_job;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			save_type_q <= SAVE_TYPE_RESET;
		end else if (psel && penable && pwrite && pready && paddr == ADDR_SAVE_TYPE) begin
			save_type_q <= pwdata[1:0];
		end
	end

	assign prdata = (paddr == ADDR_SAVE_TYPE) ? {30'd0, save_type_q} : 32'd0;

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;

	smsc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.save_type (save_type_q),
		.accept    (accept),
		.req_type  (s_tuser[2:0]),
		.address   (s_tdata[23:0]),
		.data_byte (s_tdata[31:24]),
		.first     (s_tuser[3]),
		.last      (s_tlast),
		.push      (push),
		.job       (push_job)
	);

	smsc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head_job (head_job),
		.empty    (q_empty),
		.full     (q_full)
	);

	smsc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head_job (head_job),
		.q_empty  (q_empty),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

[verif/spi_action_checker.sv]
`timescale 1ns / 1ps

module spi_action_checker #(
	parameter logic [1:0] TYPE_REG_ADDR = 2'd0
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,   // address[23:0], data_byte[31:24]
	input  logic [3:0]  s_tuser,   // req_type[2:0], first[3]
	input  logic        s_tlast,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [7:0]  m_tdata,   // bus_byte[7:0]
	input  logic [2:0]  m_tuser,   // action[2:0]
	input  logic        m_tlast,
	output int          fails,
	output int          pending
);
	import smsc_pkg::*;

	typedef struct packed {
		action_t    act;
		logic [7:0] bval;
		logic       eor;
	} bus_op_t;

	logic [1:0]  save_type_q;
	logic        frame_open;
	logic [8:0]  chunk_cnt;
	logic [23:0] next_addr;

	bus_op_t ops_due[$];
	bus_op_t item_ops[NUM_SLOTS];
	int      n_item_ops;

	task automatic put_op(input action_t act, input logic [7:0] b);
		item_ops[n_item_ops].act  = act;
		item_ops[n_item_ops].bval = (act == ACT_SEND) ? b : 8'h00;
		item_ops[n_item_ops].eor  = 1'b0;
		n_item_ops++;
	endtask

	task automatic poll_status();
		put_op(ACT_SELECT, 8'h00);
		put_op(ACT_SEND, CMD_RDSR);
		put_op(ACT_WAIT, 8'h00);
		put_op(ACT_DESELECT, 8'h00);
	endtask

	task automatic enable_write();
		put_op(ACT_SELECT, 8'h00);
		put_op(ACT_SEND, CMD_WREN);
		put_op(ACT_DESELECT, 8'h00);
	endtask

	// A write frame with bytes in it also needs the busy poll once deselected.
	task automatic close_frame();
		if (frame_open) begin
			put_op(ACT_DESELECT, 8'h00);
			if (chunk_cnt != 9'd0)
				poll_status();
		end
		frame_open = 1'b0;
		chunk_cnt  = 9'd0;
	endtask

	task automatic send_cmd_addr(input logic [7:0] cmd, input logic [23:0] a,
			input logic [1:0] t);
		if (t == TYPE_SMALL) begin
			put_op(ACT_SEND, cmd | {4'b0000, a[8], 3'b000});
		end else begin
			put_op(ACT_SEND, cmd);
			if (t == TYPE_FLASH)
				put_op(ACT_SEND, a[23:16]);
			put_op(ACT_SEND, a[15:8]);
		end
		put_op(ACT_SEND, a[7:0]);
	endtask

	function automatic logic [8:0] chunk_limit(input logic [1:0] t);
		case (t)
			TYPE_SMALL: return CHUNK_SMALL;
			TYPE_EE16:  return CHUNK_EE16;
			default:    return CHUNK_FLASH;
		endcase
	endfunction

	task automatic predict_item(input logic [2:0] req, input logic [23:0] addr,
			input logic [7:0] d, input logic first, input logic last);
		logic [1:0]  t;
		logic [23:0] a;
		t = save_type_q;
		n_item_ops = 0;
		case (req)
			REQ_READ: begin
				if (t != TYPE_NONE) begin
					if (first || !frame_open || chunk_cnt != 9'd0) begin
						close_frame();
						a = first ? addr : next_addr;
						put_op(ACT_SELECT, 8'h00);
						send_cmd_addr(CMD_READ, a, t);
						frame_open = 1'b1;
						chunk_cnt  = 9'd0;
					end else begin
						a = next_addr;
					end
					put_op(ACT_RECV, 8'h00);
					next_addr = a + 24'd1;
					if (last) begin
						put_op(ACT_DESELECT, 8'h00);
						frame_open = 1'b0;
					end
				end
			end
			REQ_WRITE: begin
				if (t != TYPE_NONE) begin
					// An open read frame has no bytes counted, so a write reopens.
					if (first || !frame_open || chunk_cnt == 9'd0) begin
						close_frame();
						a = first ? addr : next_addr;
						enable_write();
						put_op(ACT_SELECT, 8'h00);
						send_cmd_addr(CMD_WRITE, a, t);
						frame_open = 1'b1;
						chunk_cnt  = 9'd0;
					end else begin
						a = next_addr;
					end
					put_op(ACT_SEND, d);
					chunk_cnt = chunk_cnt + 9'd1;
					next_addr = a + 24'd1;
					if (chunk_cnt >= chunk_limit(t) || last) begin
						put_op(ACT_DESELECT, 8'h00);
						poll_status();
						frame_open = 1'b0;
						chunk_cnt  = 9'd0;
					end
				end
			end
			REQ_ID: begin
				close_frame();
				put_op(ACT_SELECT, 8'h00);
				put_op(ACT_SEND, CMD_RDID);
				put_op(ACT_RECV, 8'h00);
				put_op(ACT_RECV, 8'h00);
				put_op(ACT_RECV, 8'h00);
				put_op(ACT_DESELECT, 8'h00);
			end
			REQ_STATUS: begin
				close_frame();
				put_op(ACT_SELECT, 8'h00);
				put_op(ACT_SEND, CMD_RDSR);
				put_op(ACT_RECV, 8'h00);
				put_op(ACT_DESELECT, 8'h00);
			end
			REQ_ERASE: begin
				if (t == TYPE_FLASH) begin
					close_frame();
					enable_write();
					put_op(ACT_SELECT, 8'h00);
					put_op(ACT_SEND, CMD_SE);
					put_op(ACT_SEND, addr[7:0]);
					put_op(ACT_SEND, 8'h00);
					put_op(ACT_SEND, 8'h00);
					put_op(ACT_DESELECT, 8'h00);
					poll_status();
				end
			end
			default: ;
		endcase
		if (n_item_ops > 0)
			item_ops[n_item_ops - 1].eor = 1'b1;
		for (int i = 0; i < n_item_ops; i++)
			ops_due.push_back(item_ops[i]);
	endtask

	always @(posedge clk or negedge arst_n) begin
		bus_op_t exp_op;
		if (!arst_n) begin
			save_type_q = SAVE_TYPE_RESET;
			frame_open  = 1'b0;
			chunk_cnt   = 9'd0;
			next_addr   = 24'd0;
			ops_due.delete();
			fails       = 0;
			pending     = 0;
		end else begin
			// An item taken at the same edge as a register write still sees the old type.
			if (s_tvalid && s_tready)
				predict_item(s_tuser[2:0], s_tdata[23:0], s_tdata[31:24], s_tuser[3],
					s_tlast);
			if (psel && penable && pwrite && pready && paddr == TYPE_REG_ADDR)
				save_type_q = pwdata[1:0];
			if (m_tvalid && m_tready) begin
				if (ops_due.size() == 0) begin
					$error("bus action %0d with byte 0x%02h arrived with nothing expected",
						m_tuser, m_tdata);
					fails++;
				end else begin
					exp_op = ops_due.pop_front();
					if (m_tuser !== exp_op.act) begin
						$error("action: expected %0d, got %0d", exp_op.act, m_tuser);
						fails++;
					end
					if (m_tdata !== exp_op.bval) begin
						$error("bus_byte: expected 0x%02h, got 0x%02h", exp_op.bval, m_tdata);
						fails++;
					end
					if (m_tlast !== exp_op.eor) begin
						$error("end_of_run: expected %0b, got %0b", exp_op.eor, m_tlast);
						fails++;
					end
				end
			end
			pending = ops_due.size();
		end
	end

endmodule

[verif/save_memory_spi_command_sequencer_unit_tb.sv]
`timescale 1ns / 1ps

module save_memory_spi_command_sequencer_unit_tb;
	import smsc_pkg::*;

	localparam logic [1:0] REG_SAVE_TYPE = 2'd0;
	localparam int RANDOM_ITEMS   = 90;
	localparam int LONG_BURST     = 257;
	localparam int DRAIN_CYCLES   = 16;
	localparam int WATCHDOG_LIMIT = 4000;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [1:0]  paddr    = 2'd0;
	logic [31:0] pwdata   = 32'd0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata  = 32'd0;
	logic [3:0]  s_tuser  = 4'd0;
	logic        s_tlast  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic [2:0]  m_tuser;
	logic        m_tlast;

	int chk_fails;
	int chk_pending;
	int send_idle_pct = 24;
	int recv_idle_pct = 73;
	int quiet_cycles  = 0;
	int items_sent    = 0;

	logic [1:0] type_cycle [4] = '{TYPE_SMALL, TYPE_FLASH, TYPE_EE16, TYPE_NONE};

	save_memory_spi_command_sequencer_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	spi_action_checker #(
		.TYPE_REG_ADDR (REG_SAVE_TYPE)
	) action_chk (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.fails    (chk_fails),
		.pending  (chk_pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(negedge clk)
		m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

	// The watchdog only counts cycles in which no beat of any kind is taken.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic push_req(input logic [2:0] req, input logic [23:0] addr,
			input logic [7:0] d, input logic first, input logic last);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {d, addr};
		s_tuser  <= {first, req};
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic push_noise();
		push_req(3'($urandom), 24'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		while (chk_pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic apb_write(input logic [1:0] addr, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic set_save_type(input logic [1:0] t);
		settle();
		apb_write(REG_SAVE_TYPE, {30'd0, t});
	endtask

	// Mostly well-formed transfers; some start without first, some never close,
	// and now and then a stray request cuts into the frame.
	task automatic random_burst();
		logic [2:0]  req;
		logic [23:0] addr;
		logic        f;
		logic        l;
		int          len;
		req  = ($urandom_range(0, 2) == 0) ? REQ_READ : REQ_WRITE;
		len  = $urandom_range(1, 40);
		addr = ($urandom_range(0, 3) == 0) ? 24'hFFFFFF - 24'($urandom_range(0, 40))
			: 24'($urandom);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 19) == 0)
				push_noise();
			f = (i == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 29) == 0);
			l = (i == len - 1) ? ($urandom_range(0, 6) != 0) : ($urandom_range(0, 29) == 0);
			push_req(req, (i == 0) ? addr : 24'($urandom), 8'($urandom), f, l);
		end
	endtask

	initial begin
		logic [1:0] cur_type;
		int         next_cfg;
		int         cfg_idx;

		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Flash type out of reset.
		push_req(REQ_ID, 24'h000000, 8'h00, 1'b0, 1'b0);
		push_req(REQ_STATUS, 24'hFFFFFF, 8'hFF, 1'b1, 1'b1);
		push_req(REQ_READ, 24'hFFFFFF, 8'h00, 1'b1, 1'b0);
		push_req(REQ_READ, 24'h000000, 8'h00, 1'b0, 1'b1);
		push_req(REQ_READ, 24'h000000, 8'h00, 1'b0, 1'b0);
		push_req(REQ_STATUS, 24'h000000, 8'h00, 1'b0, 1'b0);
		push_req(REQ_WRITE, 24'h123456, 8'hFF, 1'b1, 1'b0);
		push_req(REQ_WRITE, 24'h000000, 8'h00, 1'b0, 1'b0);
		push_req(REQ_READ, 24'h000000, 8'h00, 1'b0, 1'b0);
		push_req(REQ_WRITE, 24'hABCDEF, 8'h5A, 1'b1, 1'b0);
		push_req(REQ_ID, 24'h000000, 8'h00, 1'b0, 1'b0);
		push_req(REQ_ERASE, 24'hFFFFAB, 8'hFF, 1'b1, 1'b1);
		push_req(REQ_ERASE, 24'h000000, 8'h00, 1'b0, 1'b0);
		for (int r = REQ_ERASE + 1; r < 8; r++)
			push_req(3'(r), 24'hFFFFFF, 8'hFF, 1'b1, 1'b1);

		// One transfer long enough to fill a whole flash page.
		for (int i = 0; i < LONG_BURST; i++)
			push_req(REQ_WRITE, 24'hFFFF80, 8'($urandom), i == 0, i == LONG_BURST - 1);

		push_req(REQ_WRITE, 24'h000100, 8'hA5, 1'b1, 1'b0);

		// The write frame stays open across the change of type.
		set_save_type(TYPE_SMALL);
		push_req(REQ_WRITE, 24'h000000, 8'h3C, 1'b0, 1'b1);
		push_req(REQ_READ, 24'h0001FF, 8'h00, 1'b1, 1'b1);
		push_req(REQ_ERASE, 24'h000012, 8'h00, 1'b0, 1'b0);

		set_save_type(TYPE_EE16);
		push_req(REQ_WRITE, 24'hFEDCBA, 8'h81, 1'b1, 1'b1);
		push_req(REQ_READ, 24'h00FFFF, 8'h00, 1'b1, 1'b1);

		set_save_type(TYPE_NONE);
		push_req(REQ_READ, 24'h000010, 8'h00, 1'b1, 1'b1);
		push_req(REQ_WRITE, 24'h000010, 8'h77, 1'b1, 1'b1);
		push_req(REQ_ERASE, 24'h000001, 8'h00, 1'b0, 1'b0);
		push_req(REQ_ID, 24'h000000, 8'h00, 1'b0, 1'b0);

		items_sent = 0;
		next_cfg   = 0;
		cfg_idx    = 0;
		while (items_sent < RANDOM_ITEMS) begin
			if (items_sent >= (2 * RANDOM_ITEMS) / 3) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end else if (items_sent >= RANDOM_ITEMS / 3) begin
				send_idle_pct = 73;
				recv_idle_pct = 24;
			end
			if (items_sent >= next_cfg) begin
				cur_type = type_cycle[cfg_idx % 4];
				cfg_idx++;
				set_save_type(cur_type);
				next_cfg = items_sent + ((cur_type == TYPE_NONE) ? 8 : 24);
			end
			if ($urandom_range(0, 99) < 70)
				random_burst();
			else
				push_noise();
		end

		settle();
		if (chk_fails == 0 && chk_pending == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
